// ===== hdl/scs_pkg.sv =====
package scs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CW_USED     = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    localparam int NUM_COORDS  = 8;
    localparam int MAG_W       = 67;
    localparam int REM_W       = MAG_W + 1;
    localparam int QUOT_W      = 63;
    localparam int DIV_STEPS   = QUOT_W;
    localparam int SQRT_STEPS  = 33;
    localparam int PROD_W      = 65;
    localparam int BAND_SHR    = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int BAND_SHL    = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

    localparam int CFG_IDX_W   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SNAP      = CFG_IDX_W'(1);
    localparam logic [31:0] TOL_RESET  = 32'd16777;
    localparam logic        SNAP_RESET = 1'b1;

    localparam logic signed [63:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_ONE  = 64'sh0000_0001_0000_0000;

    typedef enum logic [1:0] {
        VERDICT_CROSS     = 2'd0,
        VERDICT_SKEW      = 2'd1,
        VERDICT_PARALLEL  = 2'd2,
        VERDICT_COLLINEAR = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        SNAP_NONE  = 3'd0,
        SNAP_F_ORG = 3'd1,
        SNAP_F_END = 3'd2,
        SNAP_E_ORG = 3'd3,
        SNAP_E_END = 3'd4
    } snap_t;

    typedef struct packed {
        logic [NUM_COORDS-1:0][31:0] crd;
        logic              par;
        logic              side_zero;
        logic              s_neg;
        logic              t_neg;
        logic              s_sat;
        logic              t_sat;
        logic [MAG_W-1:0]  den_mag;
        logic [REM_W-1:0]  s_rem;
        logic [REM_W-1:0]  t_rem;
        logic [QUOT_W-1:0] s_nlo;
        logic [QUOT_W-1:0] t_nlo;
        logic [QUOT_W-1:0] s_q;
        logic [QUOT_W-1:0] t_q;
        logic [MAG_W-1:0]  e_op;
        logic [MAG_W-1:0]  e_res;
        logic [MAG_W-1:0]  f_op;
        logic [MAG_W-1:0]  f_res;
        logic [PROD_W-1:0] e_prod;
        logic [PROD_W-1:0] f_prod;
        logic [QUOT_W-1:0] e_band;
        logic [QUOT_W-1:0] f_band;
    } chain_t;

    function automatic logic [31:0] coord_ext(input logic [31:0] v);
        return 32'($signed(v[CW_USED-1:0]));
    endfunction

endpackage

// ===== hdl/segment_crossing_with_snap_top.sv =====
// throughput: one word per cycle while the output is not stalled; the 63-stage
// quotient pipeline and the 33-stage square-root steps inside it set the depth,
// every stage takes a new word
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset: rst_n async low clears all valid bits, tolerance to 16777, snap_enable to 1
module segment_crossing_with_snap_top
    import scs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // e_origin_x, e_origin_y, e_end_x, e_end_y, f_origin_x, f_origin_y, f_end_x, f_end_y
    input  logic [255:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // verdict, snapped_to, point_x, point_y, zero pad
    output logic [71:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic        adv;
    logic [31:0] tol_reg;
    logic        snap_en_reg;

    // front stage a: coordinates and differences
    logic [NUM_COORDS-1:0][31:0] cin;
    logic [NUM_COORDS-1:0][31:0] crd_a_reg, crd_b_reg, crd_c_reg, crd_d_reg;
    logic signed [32:0] dex_a_reg, dey_a_reg, dfx_a_reg, dfy_a_reg, wx_a_reg, wy_a_reg;
    // stage b: products
    logic signed [65:0] pd1_b_reg, pd2_b_reg, ps1_b_reg, ps2_b_reg, pt1_b_reg, pt2_b_reg;
    logic signed [65:0] sqex_b_reg, sqey_b_reg, sqfx_b_reg, sqfy_b_reg;
    // stage c: determinants and squared lengths
    logic signed [MAG_W-1:0] den_c_reg, nums_c_reg, numt_c_reg;
    logic [MAG_W-1:0]        ve_c_reg, vf_c_reg;
    // stage d: magnitudes
    logic [MAG_W-1:0] den_d_reg, nums_d_reg, numt_d_reg, ve_d_reg, vf_d_reg;
    logic             par_d_reg, side_zero_d_reg, s_neg_d_reg, t_neg_d_reg;

    logic   va_reg, vb_reg, vc_reg, vd_reg;
    logic   vld_reg [0:DIV_STEPS];
    chain_t chain_reg [0:DIV_STEPS];

    // tail stages
    logic               f1_vld_reg, f2_vld_reg, f3_vld_reg, out_vld_reg;
    logic signed [63:0] s_f1_reg, t_f1_reg, ope_f1_reg, opf_f1_reg;
    logic [QUOT_W-1:0]  be_f1_reg, bf_f1_reg;
    logic signed [32:0] dfx_f1_reg, dfy_f1_reg;
    logic               par_f1_reg, side_zero_f1_reg;
    logic [NUM_COORDS-1:0][31:0] crd_f1_reg, crd_f2_reg, crd_f3_reg;

    logic signed [64:0] pxh_f2_reg, pyh_f2_reg;
    logic signed [65:0] pxl_f2_reg, pyl_f2_reg;
    verdict_t           verdict_f2_reg, verdict_f3_reg;
    snap_t              snap_f2_reg, snap_f3_reg;
    logic signed [66:0] sx_f3_reg, sy_f3_reg;

    verdict_t    verdict_reg;
    snap_t       snap_reg;
    logic [31:0] px_reg, py_reg;

    assign adv       = !out_vld_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {3'b000, py_reg, px_reg, snap_reg, verdict_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= TOL_RESET;
            snap_en_reg <= SNAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TOLERANCE)
                tol_reg <= cfg_data;
            else if (cfg_index == REG_SNAP)
                snap_en_reg <= cfg_data[0];
        end
    end

    function automatic logic signed [32:0] sx33(input logic [31:0] v);
        return 33'($signed(v));
    endfunction

    function automatic logic [QUOT_W-1:0] band_scale(input logic [PROD_W-1:0] p);
        logic [127:0] w;
        w = 128'(p);
        w = (w >> BAND_SHR) << BAND_SHL;
        if (w > 128'(Q_MAX))
            return '1;
        return w[QUOT_W-1:0];
    endfunction

    // one quotient bit for s and t, one root bit for both lengths, then the bands
    function automatic chain_t chain_step(input int k, input chain_t c,
                                          input logic [31:0] tol);
        chain_t           r;
        logic [REM_W-1:0] rs;
        logic [REM_W-1:0] rt;
        logic [REM_W-1:0] dd;
        logic [MAG_W-1:0] one;
        logic [MAG_W-1:0] tmp;
        int               sh;
        r  = c;
        dd = {1'b0, c.den_mag};
        rs = {c.s_rem[REM_W-2:0], c.s_nlo[QUOT_W-1]};
        rt = {c.t_rem[REM_W-2:0], c.t_nlo[QUOT_W-1]};
        r.s_nlo = c.s_nlo << 1;
        r.t_nlo = c.t_nlo << 1;
        if (rs >= dd)
        begin
            r.s_rem = rs - dd;
            r.s_q   = {c.s_q[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.s_rem = rs;
            r.s_q   = {c.s_q[QUOT_W-2:0], 1'b0};
        end
        if (rt >= dd)
        begin
            r.t_rem = rt - dd;
            r.t_q   = {c.t_q[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.t_rem = rt;
            r.t_q   = {c.t_q[QUOT_W-2:0], 1'b0};
        end
        if (k < SQRT_STEPS)
        begin
            sh  = 2 * (SQRT_STEPS - 1 - k);
            one = MAG_W'(1) << sh;
            tmp = c.e_res + one;
            if (c.e_op >= tmp)
            begin
                r.e_op  = c.e_op - tmp;
                r.e_res = (c.e_res >> 1) + one;
            end
            else
                r.e_res = c.e_res >> 1;
            tmp = c.f_res + one;
            if (c.f_op >= tmp)
            begin
                r.f_op  = c.f_op - tmp;
                r.f_res = (c.f_res >> 1) + one;
            end
            else
                r.f_res = c.f_res >> 1;
        end
        if (k == SQRT_STEPS)
        begin
            r.e_prod = PROD_W'(tol) * PROD_W'(c.e_res[SQRT_STEPS-1:0]);
            r.f_prod = PROD_W'(tol) * PROD_W'(c.f_res[SQRT_STEPS-1:0]);
        end
        if (k == SQRT_STEPS + 1)
        begin
            r.e_band = band_scale(c.e_prod);
            r.f_band = band_scale(c.f_prod);
        end
        return r;
    endfunction

    function automatic logic signed [63:0] one_plus(input logic [QUOT_W-1:0] b);
        logic signed [63:0] bs;
        bs = $signed(64'(b));
        if (bs > Q_MAX - Q_ONE)
            return Q_MAX;
        return Q_ONE + bs;
    endfunction

    function automatic logic [31:0] clamp_coord(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = (68'sd1 <<< (CW_USED - 1)) - 68'sd1;
        lo = -hi - 68'sd1;
        if (v > hi)
            return hi[31:0];
        if (v < lo)
            return lo[31:0];
        return v[31:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < NUM_COORDS; i++)
            cin[i] = coord_ext(s_tdata[32*i +: 32]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            vd_reg      <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
                vld_reg[k] <= 1'b0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            f3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg     <= s_tvalid;
            vb_reg     <= va_reg;
            vc_reg     <= vb_reg;
            vd_reg     <= vc_reg;
            vld_reg[0] <= vd_reg;
            for (int k = 0; k < DIV_STEPS; k++)
                vld_reg[k+1] <= vld_reg[k];
            f1_vld_reg  <= vld_reg[DIV_STEPS];
            f2_vld_reg  <= f1_vld_reg;
            f3_vld_reg  <= f2_vld_reg;
            out_vld_reg <= f3_vld_reg;
        end
    end

    // front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crd_a_reg <= cin;
            dex_a_reg <= sx33(cin[2]) - sx33(cin[0]);
            dey_a_reg <= sx33(cin[3]) - sx33(cin[1]);
            dfx_a_reg <= sx33(cin[6]) - sx33(cin[4]);
            dfy_a_reg <= sx33(cin[7]) - sx33(cin[5]);
            wx_a_reg  <= sx33(cin[0]) - sx33(cin[4]);
            wy_a_reg  <= sx33(cin[1]) - sx33(cin[5]);

            crd_b_reg  <= crd_a_reg;
            pd1_b_reg  <= dfy_a_reg * dex_a_reg;
            pd2_b_reg  <= dfx_a_reg * dey_a_reg;
            ps1_b_reg  <= dfy_a_reg * wx_a_reg;
            ps2_b_reg  <= dfx_a_reg * wy_a_reg;
            pt1_b_reg  <= dex_a_reg * wy_a_reg;
            pt2_b_reg  <= dey_a_reg * wx_a_reg;
            sqex_b_reg <= dex_a_reg * dex_a_reg;
            sqey_b_reg <= dey_a_reg * dey_a_reg;
            sqfx_b_reg <= dfx_a_reg * dfx_a_reg;
            sqfy_b_reg <= dfy_a_reg * dfy_a_reg;

            crd_c_reg  <= crd_b_reg;
            den_c_reg  <= MAG_W'(pd1_b_reg) - MAG_W'(pd2_b_reg);
            nums_c_reg <= MAG_W'(ps1_b_reg) - MAG_W'(ps2_b_reg);
            numt_c_reg <= MAG_W'(pt1_b_reg) - MAG_W'(pt2_b_reg);
            ve_c_reg   <= $unsigned(MAG_W'(sqex_b_reg) + MAG_W'(sqey_b_reg));
            vf_c_reg   <= $unsigned(MAG_W'(sqfx_b_reg) + MAG_W'(sqfy_b_reg));

            crd_d_reg       <= crd_c_reg;
            den_d_reg       <= $unsigned(den_c_reg[MAG_W-1] ? -den_c_reg : den_c_reg);
            nums_d_reg      <= $unsigned(nums_c_reg[MAG_W-1] ? -nums_c_reg : nums_c_reg);
            numt_d_reg      <= $unsigned(numt_c_reg[MAG_W-1] ? -numt_c_reg : numt_c_reg);
            ve_d_reg        <= ve_c_reg;
            vf_d_reg        <= vf_c_reg;
            par_d_reg       <= (den_c_reg == '0);
            side_zero_d_reg <= (nums_c_reg == '0);
            s_neg_d_reg     <= (nums_c_reg[MAG_W-1] == den_c_reg[MAG_W-1]);
            t_neg_d_reg     <= (numt_c_reg[MAG_W-1] != den_c_reg[MAG_W-1]);
        end
    end

    // entry of the quotient / root pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chain_reg[0].crd       <= crd_d_reg;
            chain_reg[0].par       <= par_d_reg;
            chain_reg[0].side_zero <= side_zero_d_reg;
            chain_reg[0].s_neg     <= s_neg_d_reg;
            chain_reg[0].t_neg     <= t_neg_d_reg;
            // quotient overflows 63 bits exactly when the top part already reaches den
            chain_reg[0].s_sat     <= (nums_d_reg >> 31) >= den_d_reg;
            chain_reg[0].t_sat     <= (numt_d_reg >> 31) >= den_d_reg;
            chain_reg[0].den_mag   <= den_d_reg;
            chain_reg[0].s_rem     <= REM_W'(nums_d_reg >> 31);
            chain_reg[0].t_rem     <= REM_W'(numt_d_reg >> 31);
            chain_reg[0].s_nlo     <= {nums_d_reg[30:0], 32'd0};
            chain_reg[0].t_nlo     <= {numt_d_reg[30:0], 32'd0};
            chain_reg[0].s_q       <= '0;
            chain_reg[0].t_q       <= '0;
            chain_reg[0].e_op      <= ve_d_reg;
            chain_reg[0].e_res     <= '0;
            chain_reg[0].f_op      <= vf_d_reg;
            chain_reg[0].f_res     <= '0;
            chain_reg[0].e_prod    <= '0;
            chain_reg[0].f_prod    <= '0;
            chain_reg[0].e_band    <= '0;
            chain_reg[0].f_band    <= '0;
            for (int k = 0; k < DIV_STEPS; k++)
                chain_reg[k+1] <= chain_step(k, chain_reg[k], tol_reg);
        end
    end

    // tail stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crd_f1_reg <= chain_reg[DIV_STEPS].crd;
            s_f1_reg   <= chain_reg[DIV_STEPS].s_neg
                          ? -$signed(64'(chain_reg[DIV_STEPS].s_sat ? '1 : chain_reg[DIV_STEPS].s_q))
                          : $signed(64'(chain_reg[DIV_STEPS].s_sat ? '1 : chain_reg[DIV_STEPS].s_q));
            t_f1_reg   <= chain_reg[DIV_STEPS].t_neg
                          ? -$signed(64'(chain_reg[DIV_STEPS].t_sat ? '1 : chain_reg[DIV_STEPS].t_q))
                          : $signed(64'(chain_reg[DIV_STEPS].t_sat ? '1 : chain_reg[DIV_STEPS].t_q));
            be_f1_reg  <= chain_reg[DIV_STEPS].e_band;
            bf_f1_reg  <= chain_reg[DIV_STEPS].f_band;
            ope_f1_reg <= one_plus(chain_reg[DIV_STEPS].e_band);
            opf_f1_reg <= one_plus(chain_reg[DIV_STEPS].f_band);
            dfx_f1_reg <= sx33(chain_reg[DIV_STEPS].crd[6]) - sx33(chain_reg[DIV_STEPS].crd[4]);
            dfy_f1_reg <= sx33(chain_reg[DIV_STEPS].crd[7]) - sx33(chain_reg[DIV_STEPS].crd[5]);
            par_f1_reg       <= chain_reg[DIV_STEPS].par;
            side_zero_f1_reg <= chain_reg[DIV_STEPS].side_zero;

            crd_f2_reg <= crd_f1_reg;
            pxh_f2_reg <= $signed(t_f1_reg[63:32]) * dfx_f1_reg;
            pyh_f2_reg <= $signed(t_f1_reg[63:32]) * dfy_f1_reg;
            pxl_f2_reg <= $signed({1'b0, t_f1_reg[31:0]}) * dfx_f1_reg;
            pyl_f2_reg <= $signed({1'b0, t_f1_reg[31:0]}) * dfy_f1_reg;
            if (par_f1_reg)
            begin
                verdict_f2_reg <= side_zero_f1_reg ? VERDICT_COLLINEAR : VERDICT_PARALLEL;
                snap_f2_reg    <= SNAP_NONE;
            end
            else if (s_f1_reg < -$signed(64'(be_f1_reg)) || s_f1_reg > ope_f1_reg
                     || t_f1_reg < -$signed(64'(bf_f1_reg)) || t_f1_reg > opf_f1_reg)
            begin
                verdict_f2_reg <= VERDICT_SKEW;
                snap_f2_reg    <= SNAP_NONE;
            end
            else
            begin
                verdict_f2_reg <= VERDICT_CROSS;
                if (!snap_en_reg)
                    snap_f2_reg <= SNAP_NONE;
                else if (t_f1_reg <= $signed(64'(bf_f1_reg)))
                    snap_f2_reg <= SNAP_F_ORG;
                else if (t_f1_reg >= Q_ONE - $signed(64'(bf_f1_reg)))
                    snap_f2_reg <= SNAP_F_END;
                else if (s_f1_reg <= $signed(64'(be_f1_reg)))
                    snap_f2_reg <= SNAP_E_ORG;
                else if (s_f1_reg >= Q_ONE - $signed(64'(be_f1_reg)))
                    snap_f2_reg <= SNAP_E_END;
                else
                    snap_f2_reg <= SNAP_NONE;
            end

            crd_f3_reg     <= crd_f2_reg;
            verdict_f3_reg <= verdict_f2_reg;
            snap_f3_reg    <= snap_f2_reg;
            // floor(t*d / 2^32) from the high and low halves of t
            sx_f3_reg      <= 67'(pxh_f2_reg) + 67'(pxl_f2_reg >>> 32);
            sy_f3_reg      <= 67'(pyh_f2_reg) + 67'(pyl_f2_reg >>> 32);

            verdict_reg <= verdict_f3_reg;
            snap_reg    <= snap_f3_reg;
            if (verdict_f3_reg != VERDICT_CROSS)
            begin
                px_reg <= '0;
                py_reg <= '0;
            end
            else
            begin
                case (snap_f3_reg)
                    SNAP_F_ORG:
                    begin
                        px_reg <= crd_f3_reg[4];
                        py_reg <= crd_f3_reg[5];
                    end
                    SNAP_F_END:
                    begin
                        px_reg <= crd_f3_reg[6];
                        py_reg <= crd_f3_reg[7];
                    end
                    SNAP_E_ORG:
                    begin
                        px_reg <= crd_f3_reg[0];
                        py_reg <= crd_f3_reg[1];
                    end
                    SNAP_E_END:
                    begin
                        px_reg <= crd_f3_reg[2];
                        py_reg <= crd_f3_reg[3];
                    end
                    default:
                    begin
                        px_reg <= clamp_coord(68'(sx_f3_reg) + 68'($signed(crd_f3_reg[4])));
                        py_reg <= clamp_coord(68'(sy_f3_reg) + 68'($signed(crd_f3_reg[5])));
                    end
                endcase
            end
        end
    end

endmodule
